@@ hdl/sldf_pkg.sv @@
package sldf_pkg;

  // Framing constants
  localparam logic [7:0]  SyncByte    = 8'h5A;
  localparam logic [16:0] HeaderBytes = 17'd6;
  localparam logic [16:0] LimitReset  = 17'd1024;

  // Register indexes on the configuration port
  localparam logic RegFrameLimit = 1'b0;

  // One result item on its way to the output stream
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       abort;
  } sldf_res_t;

endpackage

@@ hdl/sldf_skid.sv @@
module sldf_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sldf_pkg::sldf_res_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sldf_pkg::sldf_res_t out_o
);
  import sldf_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  sldf_res_t main_q, main_d;
  sldf_res_t skid_q, skid_d;
  logic      push, pop;

  // Ready depends only on the skid slot, never on the downstream ready.
  assign in_ready_o  = ~skid_valid_q;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = main_valid_q & out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      main_valid_d = 1'b0;
    end
    if (pop && skid_valid_q) begin
      main_d       = skid_q;
      main_valid_d = 1'b1;
      skid_valid_d = 1'b0;
    end
    if (push) begin
      if (!main_valid_q || pop) begin
        main_d       = in_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = in_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot holds an item while the main slot is empty");

  a_skid_drains_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_q == $past(skid_q)))
    else $error("skid item not moved to the main slot on pop");

endmodule

@@ hdl/sync_length_frame_deframer.sv @@
// Each result item is registered in the output buffer before it appears on m_axis.
// Throughput: one input item per cycle while s_axis_tready is high; the two-slot
//   output buffer takes one more item into its skid slot after m_axis stalls.
// Reset (rst_ni, asynchronous, active low): hunting with no sync byte seen,
//   counters cleared, frame_limit back to 1024, output buffer empty.
module sync_length_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // frame_last
  output logic [1:0]  m_axis_tuser,   // [0] frame_first, [1] frame_abort
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sldf_pkg::*;

  // Parser phases
  localparam logic [1:0] PhHunt  = 2'd0;  // no sync byte seen
  localparam logic [1:0] PhOne   = 2'd1;  // one 0x5A seen
  localparam logic [1:0] PhFrame = 2'd2;  // inside a frame

  logic [1:0]  phase_q, phase_d;
  logic [16:0] byte_index_q, byte_index_d;
  logic [7:0]  length_low_q, length_low_d;
  logic [16:0] frame_total_q, frame_total_d;
  logic [16:0] frame_limit_q;

  logic        in_acc;
  logic        res_push;
  sldf_res_t   res;
  sldf_res_t   out_res;
  logic [16:0] total_calc;
  logic        cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration: single register, written at the APB access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegFrameLimit) ? {15'd0, frame_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= LimitReset;
    end else if (cfg_wr && (paddr[2] == RegFrameLimit)) begin
      frame_limit_q <= pwdata[16:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Parser: one item per cycle unless stalled; state updated at acceptance
  // ---------------------------------------------------------------------------
  assign in_acc = s_axis_tvalid & s_axis_tready;

  // Total from the little-endian length: high byte arrives now, low byte held.
  assign total_calc = {1'b0, s_axis_tdata, length_low_q} + HeaderBytes;

  always_comb begin
    phase_d       = phase_q;
    byte_index_d  = byte_index_q;
    length_low_d  = length_low_q;
    frame_total_d = frame_total_q;
    res_push      = 1'b0;
    res           = '0;
    if (in_acc) begin
      case (phase_q)
        PhOne: begin
          if (s_axis_tdata == SyncByte) begin
            // sync pair complete: one start item stands for both bytes
            phase_d       = PhFrame;
            byte_index_d  = 17'd2;
            length_low_d  = 8'd0;
            frame_total_d = 17'd0;
            res_push      = 1'b1;
            res.data      = SyncByte;
            res.first     = 1'b1;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhFrame: begin
          byte_index_d = byte_index_q + 17'd1;
          res_push     = 1'b1;
          res.data     = s_axis_tdata;
          if (byte_index_q == 17'd4) begin
            length_low_d = s_axis_tdata;
          end else if (byte_index_q == 17'd5) begin
            frame_total_d = total_calc;
            if (total_calc > frame_limit_q) begin
              // oversize: flag on the length byte and hunt again
              res.abort    = 1'b1;
              phase_d      = PhHunt;
              byte_index_d = 17'd0;
            end else if (total_calc == HeaderBytes) begin
              // empty payload ends on the length byte
              res.last     = 1'b1;
              phase_d      = PhHunt;
              byte_index_d = 17'd0;
            end
          end else if (byte_index_q > 17'd5) begin
            if (({1'b0, byte_index_q} + 18'd1) >= {1'b0, frame_total_q}) begin
              res.last     = 1'b1;
              phase_d      = PhHunt;
              byte_index_d = 17'd0;
            end
          end
        end
        default: begin
          // hunting; the unused code behaves the same
          if (s_axis_tdata == SyncByte) begin
            phase_d = PhOne;
          end else begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHunt;
      byte_index_q  <= 17'd0;
      length_low_q  <= 8'd0;
      frame_total_q <= 17'd0;
    end else begin
      phase_q       <= phase_d;
      byte_index_q  <= byte_index_d;
      length_low_q  <= length_low_d;
      frame_total_q <= frame_total_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register with skid slot
  // ---------------------------------------------------------------------------
  sldf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_push),
    .in_ready_o  (s_axis_tready),
    .in_i        (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = {out_res.abort, out_res.first};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_first_from_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.first) |-> (phase_q == PhOne))
    else $error("start item issued outside the one-sync phase");

  a_last_abort_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !(res.last && res.abort))
    else $error("item flagged both last and aborted");

  a_frame_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhFrame) |-> (byte_index_q >= 17'd2))
    else $error("frame offset below the header bytes");

  a_end_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res.last || res.abort)) |=> (phase_q == PhHunt))
    else $error("parser did not return to hunting after a frame end");

endmodule
